// ===== rtl/core/signed_int_to_decimal_ascii_defines.svh =====
// assertion macros for the signed integer to decimal text block
// no dependencies; included by the top level only
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, off during reset
`define SIDAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SIDAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sidas_pkg.sv =====
// shared constants and types for the signed integer to decimal text block
// no dependencies
package sidas_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int TEXT_W          = 6;
  localparam int OUT_TDATA_W     = 8;

  // floor(w * log10(2)) + 1 digits cover any w-bit magnitude
  localparam int LOG10_2_NUM = 1233;
  localparam int LOG10_2_DEN = 4096;

  localparam logic [TEXT_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [TEXT_W-1:0] ASCII_MINUS = 6'd45;
  localparam logic [TEXT_W-1:0] ASCII_NINE  = 6'd57;

  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

endpackage

// ===== rtl/core/sidas_dabble.sv =====
// bit-serial binary to bcd converter (shift and add-3), one bit per cycle
// depends on sidas_pkg
module sidas_dabble import sidas_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int NUM_DIGITS  = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [VALUE_WIDTH-1:0]    mag,
  output logic [NUM_DIGITS*4-1:0]   bcd,
  output dab_stat_t                 stat
);

  localparam int CntW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0]  sh;
  logic [CntW-1:0]         cnt;
  logic [NUM_DIGITS*4-1:0] corr;
  logic                    done;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        corr[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        corr[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CntW'(1));
      if (start) begin
        sh  <= mag;
        bcd <= '0;
        cnt <= CntW'(VALUE_WIDTH);
      end else if (cnt != '0) begin
        bcd <= {corr[NUM_DIGITS*4-2:0], sh[VALUE_WIDTH-1]};
        sh  <= {sh[VALUE_WIDTH-2:0], 1'b0};
        cnt <= cnt - CntW'(1);
      end
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

// ===== rtl/core/sidas_emit.sv =====
// character emitter: sign, leading-zero skip, one digit per cycle while the output
// is not stalled, into an output register; depends on sidas_pkg
module sidas_emit import sidas_pkg::*; #(
  parameter int NUM_DIGITS = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic [NUM_DIGITS*4-1:0]  bcd,
  input  logic                     neg,
  output logic                     busy,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_TDATA_W-1:0]   m_tdata,   // [5:0] text_char, [7:6] zero
  output logic                     m_tlast    // last_char
);

  localparam int RemW = $clog2(NUM_DIGITS + 1);

  typedef enum logic {
    EM_IDLE,
    EM_RUN
  } em_state_t;

  em_state_t               state;
  logic [NUM_DIGITS*4-1:0] dg;
  logic [RemW-1:0]         rem;
  logic                    sign_pend;
  logic                    lead;
  logic                    slot_free;
  logic                    skip;
  logic                    fire;
  logic [3:0]              top_digit;

  assign top_digit = dg[NUM_DIGITS*4-1 -: 4];
  assign slot_free = !m_tvalid || m_tready;
  // drop leading zeros only, and always keep the final digit
  assign skip      = lead && (top_digit == 4'd0) && (rem > RemW'(1));
  // a word enters the output register this cycle
  assign fire      = (state == EM_RUN) && slot_free && (sign_pend || !skip);
  assign busy      = (state == EM_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= EM_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        EM_IDLE: begin
          if (load) begin
            dg        <= bcd;
            rem       <= RemW'(NUM_DIGITS);
            sign_pend <= neg;
            lead      <= 1'b1;
            state     <= EM_RUN;
          end
        end
        EM_RUN: begin
          if (skip) begin
            dg  <= {dg[NUM_DIGITS*4-5:0], 4'd0};
            rem <= rem - RemW'(1);
          end
          if (sign_pend) begin
            if (slot_free) begin
              m_tdata   <= {2'b00, ASCII_MINUS};
              m_tlast   <= 1'b0;
              sign_pend <= 1'b0;
            end
          end else if (!skip && slot_free) begin
            m_tdata  <= {2'b00, ASCII_ZERO + {2'b00, top_digit}};
            m_tlast  <= (rem == RemW'(1));
            dg       <= {dg[NUM_DIGITS*4-5:0], 4'd0};
            rem      <= rem - RemW'(1);
            lead     <= 1'b0;
            if (rem == RemW'(1)) begin
              state <= EM_IDLE;
            end
          end
        end
        default: state <= EM_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// channel  dir  tdata                         tlast      tuser
// s_       in   value (VALUE_WIDTH, signed)   -          -
// m_       out  text_char (6, [5:0])          last_char  -
//
// one value in, its decimal text out one character per word
// a value passes through the bit-serial bcd converter, one shift per value bit,
// then loads the emitter, which steps through all NUM_DIGITS digits (leading-zero
// skips plus sent digits) before the next value is taken;
// a minus sign shares a leading-zero skip, or adds a step when there is no leading zero
// the next value is taken while the final character waits in the output register
// reset is synchronous and active high; output stalls hold the emitter
// depends on sidas_pkg, sidas_dabble, sidas_emit and the defines header
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii import sidas_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // [VALUE_WIDTH-1:0] value
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [OUT_TDATA_W-1:0]                m_tdata,   // [5:0] text_char
  output logic                                  m_tlast    // last_char
);

  localparam int NumDigits = (VALUE_WIDTH * LOG10_2_NUM) / LOG10_2_DEN + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t                   state;
  logic                     neg;
  logic                     accept;
  logic [VALUE_WIDTH-1:0]   value;
  logic [VALUE_WIDTH-1:0]   mag;
  logic [NumDigits*4-1:0]   bcd;
  dab_stat_t                dab_stat;
  logic                     emit_busy;

  assign value    = s_tdata[VALUE_WIDTH-1:0];
  // the most negative value negates to itself, which is its magnitude unsigned
  assign mag      = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
  assign s_tready = (state == ST_IDLE) || ((state == ST_EMIT) && !emit_busy);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            neg   <= value[VALUE_WIDTH-1];
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (dab_stat.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (accept) begin
            neg   <= value[VALUE_WIDTH-1];
            state <= ST_CONV;
          end else if (!emit_busy) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  sidas_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NumDigits)
  ) u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .mag   (mag),
    .bcd   (bcd),
    .stat  (dab_stat)
  );

  sidas_emit #(
    .NUM_DIGITS (NumDigits)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (dab_stat.done),
    .bcd      (bcd),
    .neg      (neg),
    .busy     (emit_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `SIDAS_ASSERT_IMP(a_minus_not_last, m_tvalid && (m_tdata[5:0] == ASCII_MINUS), !m_tlast, "minus sign flagged as last character")
  `SIDAS_ASSERT_NXT(a_one_at_a_time, accept, !s_tready, "second value taken during conversion")
  `SIDAS_ASSERT_IMP(a_done_in_conv, dab_stat.done, state == ST_CONV, "converter finished outside conversion")
  `SIDAS_ASSERT_IMP(a_accept_conv_free, accept, !dab_stat.busy && !emit_busy, "value taken while a unit is busy")

endmodule
